FILE: rtl/hklc_pkg.sv
// ----------------------------------------------------------------------------
// hklc_pkg: shared definitions for the held key list
// Operation codes, result kinds and the cell control group.
// ----------------------------------------------------------------------------
package hklc_pkg;

  localparam int unsigned OP_BITS    = 2;
  localparam int unsigned KIND_BITS  = 3;
  localparam int unsigned KEY_W      = 16;
  localparam int unsigned HCOUNT_W   = 4;

  localparam logic [OP_BITS-1:0] OP_ADD     = 2'd0;
  localparam logic [OP_BITS-1:0] OP_REMOVE  = 2'd1;
  localparam logic [OP_BITS-1:0] OP_RELEASE = 2'd2;

  localparam logic [KIND_BITS-1:0] KIND_ADDED     = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_OVERFLOW  = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_REMOVED   = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_NOT_FOUND = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_RELEASE   = 3'd4;
  localparam logic [KIND_BITS-1:0] KIND_EMPTY     = 3'd5;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

FILE: rtl/hklc_if.sv
// ----------------------------------------------------------------------------
// hklc_if: item channels of the held key list
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
interface hklc_in_if;
  import hklc_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_BITS-1:0]  op;
  logic [KEY_W-1:0]    key_id;

  modport source (output valid, output op, output key_id, input ready);
  modport sink   (input valid, input op, input key_id, output ready);
endinterface

interface hklc_out_if;
  import hklc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KIND_BITS-1:0] kind;
  logic [KEY_W-1:0]     out_key;
  logic [HCOUNT_W-1:0]  held_count;
  logic                 last;

  modport source (output valid, output kind, output out_key, output held_count,
                  output last, input ready);
  modport sink   (input valid, input kind, input out_key, input held_count,
                  input last, output ready);
endinterface

FILE: rtl/held_key_list_compacting_core.sv
// ----------------------------------------------------------------------------
// held_key_list_compacting_core: ordered list of held keys with compaction
// A row of DEPTH cells with the list head in cell 0; adds, removes and
// releases the held keys and reports each operation as result items.
// ----------------------------------------------------------------------------
// An add is answered directly: the result is available in the cycle after
// the item is accepted. A remove rotates the list once through the head cell,
// one entry per cycle, and its result follows once the rotation has passed
// every held entry. A release-all shifts one entry out of the head cell per
// cycle and emits one result item per cycle while the output is taken, one
// item per held entry. The block works on one item at a time and accepts
// the next item once the last result of the previous one has been taken.
module held_key_list_compacting_core #(
  parameter int unsigned DEPTH    = 8,
  parameter int unsigned KEY_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  hklc_in_if.sink      in_chan,
  hklc_out_if.source   out_chan
);
  import hklc_pkg::*;

  localparam int unsigned KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_REL  = 3'b100
  } state_t;

  function automatic logic [HCOUNT_W-1:0] to_cnt4(input logic [CW-1:0] c);
    logic [CW+HCOUNT_W-1:0] x;
    x = {{HCOUNT_W{1'b0}}, c};
    return x[HCOUNT_W-1:0];
  endfunction

  function automatic logic [KEY_W-1:0] to_key16(input logic [KW-1:0] k);
    logic [KW+KEY_W-1:0] x;
    x = {{KEY_W{1'b0}}, k};
    return x[KEY_W-1:0];
  endfunction

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        steps_r, steps_nxt;
  logic                 found_r, found_nxt;
  logic [KW-1:0]        key_r, key_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [KIND_BITS-1:0] out_kind_r, out_kind_nxt;
  logic [KEY_W-1:0]     out_key_r, out_key_nxt;
  logic [HCOUNT_W-1:0]  out_count_r, out_count_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 in_acc;
  logic                 out_free;
  logic [KW-1:0]        in_key;
  logic [KW-1:0]        head;
  logic [CW-1:0]        count_inc;
  logic [CW-1:0]        count_dec;
  logic                 add_wr;
  logic                 scan_step;
  logic                 rel_step;
  logic                 discard;
  logic [KW-1:0]        load_data;
  logic [KW-1:0]        cell_q [DEPTH];

  assign in_chan.ready = (state_r == S_IDLE) && !out_valid_r;
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;
  assign in_key        = in_chan.key_id[KW-1:0];
  assign head          = cell_q[0];
  assign count_inc     = count_r + 1'b1;
  assign count_dec     = count_r - 1'b1;
  assign load_data     = add_wr ? in_key : head;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    steps_nxt     = steps_r;
    found_nxt     = found_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_kind_nxt  = out_kind_r;
    out_key_nxt   = out_key_r;
    out_count_nxt = out_count_r;
    out_last_nxt  = out_last_r;
    add_wr        = 1'b0;
    scan_step     = 1'b0;
    rel_step      = 1'b0;
    discard       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_chan.op)
            OP_ADD: begin
              out_valid_nxt = 1'b1;
              out_key_nxt   = to_key16(in_key);
              out_last_nxt  = 1'b1;
              if (count_r < CW'(DEPTH)) begin
                add_wr        = 1'b1;
                count_nxt     = count_inc;
                out_kind_nxt  = KIND_ADDED;
                out_count_nxt = to_cnt4(count_inc);
              end else begin
                out_kind_nxt  = KIND_OVERFLOW;
                out_count_nxt = to_cnt4(count_r);
              end
            end
            OP_REMOVE: begin
              key_nxt   = in_key;
              steps_nxt = count_r;
              found_nxt = 1'b0;
              state_nxt = S_SCAN;
            end
            OP_RELEASE: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_EMPTY;
                out_key_nxt   = '0;
                out_count_nxt = '0;
                out_last_nxt  = 1'b1;
              end else begin
                state_nxt = S_REL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (steps_r == '0) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = found_r ? KIND_REMOVED : KIND_NOT_FOUND;
          out_key_nxt   = to_key16(key_r);
          out_count_nxt = to_cnt4(count_r);
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          scan_step = 1'b1;
          discard   = !found_r && (head == key_r);
          steps_nxt = steps_r - 1'b1;
          if (discard) begin
            found_nxt = 1'b1;
            count_nxt = count_dec;
          end
        end
      end
      S_REL: begin
        if (out_free) begin
          rel_step      = 1'b1;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_RELEASE;
          out_key_nxt   = to_key16(head);
          out_count_nxt = to_cnt4(count_dec);
          out_last_nxt  = (count_r == CW'(1));
          count_nxt     = count_dec;
          if (count_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctrl_t    ctrl;
    logic [KW-1:0] upper;

    assign ctrl.shift = scan_step || rel_step;
    assign ctrl.load  = (add_wr && (count_r == CW'(i))) ||
                        (scan_step && !discard && (count_r == CW'(i + 1)));
    if (i == DEPTH - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid
      assign upper = cell_q[i + 1];
    end

    hklc_cell #(
      .KW (KW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .load_data  (load_data),
      .shift_data (upper),
      .data_q     (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      steps_r     <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      steps_r     <= steps_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    out_kind_r  <= out_kind_nxt;
    out_key_r   <= out_key_nxt;
    out_count_r <= out_count_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.kind       = out_kind_r;
  assign out_chan.out_key    = out_key_r;
  assign out_chan.held_count = out_count_r;
  assign out_chan.last       = out_last_r;

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("held entry count exceeds the list depth");

  a_rel_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REL) |-> (count_r != '0))
    else $error("release in progress on an empty list");

  a_scan_steps : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (steps_r <= count_r))
    else $error("remove scan has more steps left than held entries");

  a_rel_done : assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_REL) && rel_step && (count_r == CW'(1))) |=>
      ((state_r == S_IDLE) && (count_r == '0) && out_chan.last))
    else $error("release did not finish with the last item and an empty list");

endmodule

FILE: rtl/hklc_cell.sv
// ----------------------------------------------------------------------------
// hklc_cell: one entry of the held key row
// Holds one key; loads a new key, takes its upper neighbour's key or holds.
// ----------------------------------------------------------------------------
module hklc_cell #(
  parameter int unsigned KW = 16
) (
  input  logic                clk,
  input  hklc_pkg::cell_ctrl_t ctrl,
  input  logic [KW-1:0]       load_data,
  input  logic [KW-1:0]       shift_data,
  output logic [KW-1:0]       data_q
);
  import hklc_pkg::*;

  logic [KW-1:0] data_r;
  logic [KW-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.load) begin
      data_nxt = load_data;
    end else if (ctrl.shift) begin
      data_nxt = shift_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

FILE: tb/hklc_result_checker.sv
// ----------------------------------------------------------------------------
// hklc_result_checker: result checker for the held key list
// Watches both item channels, keeps its own copy of the held list, predicts
// the result items of every accepted operation and compares them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hklc_result_checker #(
  parameter int unsigned DEPTH    = 8,
  parameter int unsigned KEY_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  hklc_in_if          in_mon,
  hklc_out_if         out_mon,
  output int unsigned fail_count,
  output int unsigned pending_results
);
  import hklc_pkg::*;

  localparam logic [KEY_W-1:0] KEY_MASK =
    (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} : KEY_W'((64'd1 << KEY_BITS) - 64'd1);

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [KEY_W-1:0]     key;
    logic [HCOUNT_W-1:0]  held_count;
    logic                 last;
  } held_result_t;

  held_result_t     awaited_results[$];
  logic [KEY_W-1:0] held_keys [DEPTH];
  int unsigned      held_total;

  function automatic held_result_t make_result(input logic [KIND_BITS-1:0] kind,
                                               input logic [KEY_W-1:0] key,
                                               input int unsigned count,
                                               input logic last);
    held_result_t r;
    r.kind       = kind;
    r.key        = key;
    r.held_count = HCOUNT_W'(count);
    r.last       = last;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR %0t ns: %s", $time, what);
    fail_count++;
  endtask

  task automatic predict_held_list(input logic [OP_BITS-1:0] op,
                                   input logic [KEY_W-1:0] key_in);
    logic [KEY_W-1:0] key;
    int               hit;
    key = key_in & KEY_MASK;
    hit = -1;
    case (op)
      OP_ADD: begin
        if (held_total < DEPTH) begin
          held_keys[held_total] = key;
          held_total++;
          awaited_results.push_back(make_result(KIND_ADDED, key, held_total, 1'b1));
        end else begin
          awaited_results.push_back(make_result(KIND_OVERFLOW, key, held_total, 1'b1));
        end
      end
      OP_REMOVE: begin
        for (int i = 0; i < int'(held_total); i++) begin
          if (hit < 0 && held_keys[i] == key) hit = i;
        end
        if (hit >= 0) begin
          for (int j = hit; j + 1 < int'(held_total); j++) held_keys[j] = held_keys[j + 1];
          held_total--;
          awaited_results.push_back(make_result(KIND_REMOVED, key, held_total, 1'b1));
        end else begin
          awaited_results.push_back(make_result(KIND_NOT_FOUND, key, held_total, 1'b1));
        end
      end
      OP_RELEASE: begin
        if (held_total == 0) begin
          awaited_results.push_back(make_result(KIND_EMPTY, '0, 0, 1'b1));
        end else begin
          for (int unsigned i = 0; i < held_total; i++) begin
            awaited_results.push_back(make_result(KIND_RELEASE, held_keys[i],
                                                  held_total - 1 - i,
                                                  i + 1 == held_total));
          end
        end
        held_total = 0;
      end
      default: ;
    endcase
  endtask

  task automatic check_result();
    held_result_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch($sformatf("result item kind %0d key %h with nothing awaited",
                                out_mon.kind, out_mon.out_key));
    end else begin
      want = awaited_results.pop_front();
      if (out_mon.kind !== want.kind)
        report_mismatch($sformatf("kind %0d, expected %0d", out_mon.kind, want.kind));
      if (out_mon.out_key !== want.key)
        report_mismatch($sformatf("out_key %h, expected %h", out_mon.out_key, want.key));
      if (out_mon.held_count !== want.held_count)
        report_mismatch($sformatf("held_count %0d, expected %0d",
                                  out_mon.held_count, want.held_count));
      if (out_mon.last !== want.last)
        report_mismatch($sformatf("last %b, expected %b", out_mon.last, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      awaited_results.delete();
      held_total = 0;
      fail_count = 0;
    end else begin
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1)
        predict_held_list(in_mon.op, in_mon.key_id);
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1)
        check_result();
    end
    pending_results <= awaited_results.size();
  end

endmodule

FILE: tb/held_key_list_compacting_core_test.sv
// ----------------------------------------------------------------------------
// held_key_list_compacting_core_test: testbench top for the held key list
// Drives directed and random add, remove, release-all and unused op items,
// random gaps and stalls on both channels, and gives the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module held_key_list_compacting_core_test;
  import hklc_pkg::*;

  localparam int unsigned DEPTH       = 8;
  localparam int unsigned KEY_BITS    = 16;
  localparam int unsigned RANDOM_OPS  = 360;
  localparam int unsigned DIRECTED_N  = 22;
  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

  localparam logic [OP_BITS+KEY_W-1:0] DIRECTED_OPS [DIRECTED_N] = '{
    {OP_RELEASE, 16'h0000}, {OP_REMOVE, 16'h1234}, {OP_UNUSED, 16'hFFFF},
    {OP_ADD, 16'h0000}, {OP_ADD, 16'hFFFF}, {OP_ADD, 16'hFFFF},
    {OP_ADD, 16'h8001}, {OP_ADD, 16'h7FFE}, {OP_ADD, 16'h5555},
    {OP_ADD, 16'hAAAA}, {OP_ADD, 16'h0001}, {OP_ADD, 16'h1234},
    {OP_REMOVE, 16'hFFFF}, {OP_REMOVE, 16'h4321}, {OP_REMOVE, 16'h0000},
    {OP_REMOVE, 16'h0001}, {OP_RELEASE, 16'hFFFF}, {OP_RELEASE, 16'h0000},
    {OP_ADD, 16'hFFFF}, {OP_REMOVE, 16'hFFFF}, {OP_ADD, 16'h00FF},
    {OP_RELEASE, 16'h0000}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        request_hold_off = 1'b0;
  int unsigned fail_count;
  int unsigned pending_results;

  hklc_in_if  in_chan ();
  hklc_out_if out_chan ();

  held_key_list_compacting_core #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  hklc_result_checker #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) result_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_chan),
    .out_mon         (out_chan),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int unsigned idle_length(inout int unsigned calm_left);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if (r < 5) begin
      calm_left = $urandom_range(20, 50);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  task automatic send_item(input logic [OP_BITS-1:0] op, input logic [KEY_W-1:0] key);
    @(negedge clk);
    in_chan.valid  = 1'b1;
    in_chan.op     = op;
    in_chan.key_id = key;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic sender_gap(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_chan.valid  = 1'b0;
      in_chan.op     = OP_BITS'($urandom_range(0, 3));
      in_chan.key_id = KEY_W'($urandom_range(0, 65535));
    end
  endtask

  initial begin : drive_ready
    int unsigned stall_left;
    int unsigned ready_calm;
    bit          hold_done;
    stall_left = 0;
    ready_calm = 0;
    hold_done  = 1'b0;
    out_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_chan.ready = 1'b0;
        stall_left--;
      end else if (request_hold_off && !hold_done) begin
        hold_done      = 1'b1;
        out_chan.ready = 1'b0;
        stall_left     = 299;
      end else begin
        out_chan.ready = 1'b1;
        stall_left     = idle_length(ready_calm);
      end
    end
  end

  initial begin : drive_items
    logic [KEY_W-1:0]   key_pool [6];
    logic [OP_BITS-1:0] op;
    logic [KEY_W-1:0]   key;
    int unsigned        sent;
    int unsigned        send_calm;
    int unsigned        r;
    sent      = 0;
    send_calm = 0;
    in_chan.valid  = 1'b0;
    in_chan.op     = OP_ADD;
    in_chan.key_id = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIRECTED_N; i++) begin
      send_item(DIRECTED_OPS[i][OP_BITS+KEY_W-1:KEY_W], DIRECTED_OPS[i][KEY_W-1:0]);
      sender_gap(idle_length(send_calm));
    end

    while (sent < RANDOM_OPS) begin
      if (sent % 40 == 0) begin
        foreach (key_pool[k]) key_pool[k] = KEY_W'($urandom_range(0, 65535));
      end
      if (sent == 120) request_hold_off = 1'b1;
      if (sent == 240) begin
        @(negedge clk);
        in_chan.valid = 1'b0;
        wait (pending_results == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 45) op = OP_ADD;
      else if (r < 80) op = OP_REMOVE;
      else if (r < 95) op = OP_RELEASE;
      else op = OP_UNUSED;
      if ($urandom_range(0, 99) < 75) key = key_pool[$urandom_range(0, 5)];
      else key = KEY_W'($urandom_range(0, 65535));
      send_item(op, key);
      if (op != OP_UNUSED) sent++;
      sender_gap(idle_length(send_calm));
    end

    @(negedge clk);
    in_chan.valid = 1'b0;
    wait (pending_results == 0);
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/hklc_pkg.sv
rtl/hklc_if.sv
rtl/hklc_cell.sv
rtl/held_key_list_compacting_core.sv
tb/hklc_result_checker.sv
tb/held_key_list_compacting_core_test.sv
